// ===== hdl/lhp_pkg.sv =====
// Shared constants and types for the latency histogram block.
package lhp_pkg;

    localparam int NS_W     = 40;
    localparam int PCT_W    = 7;
    localparam int BIDX_W   = 5;
    localparam int COUNT_W  = 40;
    localparam int SUM_W    = 64;
    localparam int PEAK_W   = 40;
    localparam int BCNT_W   = 32;
    localparam int PROD_W   = COUNT_W + PCT_W;

    localparam int BUCKETS_DEF = 32;

    localparam longint unsigned NS_PER_MS = 64'd1000000;
    localparam int unsigned     PCT_SCALE = 100;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } lhp_state_t;

endpackage

// ===== hdl/lhp_req_if.sv =====
// Request and response channel interfaces of the latency histogram.
interface lhp_req_if import lhp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [NS_W-1:0]   duration_ns;
    logic [PCT_W-1:0]  percent;

    modport source (output valid, mode, duration_ns, percent, input ready);
    modport sink   (input valid, mode, duration_ns, percent, output ready);
endinterface

interface lhp_rsp_if import lhp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BIDX_W-1:0]  bucket_index;
    logic [COUNT_W-1:0] sample_count;
    logic [SUM_W-1:0]   total_elapsed;
    logic [PEAK_W-1:0]  max_elapsed;

    modport source (output valid, bucket_index, sample_count, total_elapsed, max_elapsed,
                    input ready);
    modport sink   (input valid, bucket_index, sample_count, total_elapsed, max_elapsed,
                    output ready);
endinterface

// ===== hdl/latency_histogram_percentile.sv =====
// Latency histogram with millisecond buckets and a percentile query. After reset the block
// clears its bucket memory, one bucket a cycle, with req.ready low. It then works on one
// item at a time and takes a new beat only while idle. A record beat goes through the
// reciprocal divide by one million, then a read and a write of its bucket, then a load of
// the output register. A query beat walks the bucket memory through its single read port,
// one bucket a cycle: it starts the read, sums one bucket at a time until the percentile
// is reached or the last bucket is passed, then loads the output register. The result waits
// in an output register, so a new beat is taken while the last one is pending; a stalled
// response holds the block before it loads the next result.
module latency_histogram_percentile import lhp_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lhp_req_if.sink       req,
    lhp_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(BUCKETS);
    // Running sum of bucket counts, scaled by the percent scale.
    localparam int ACC_W = BCNT_W + PCT_W + IDX_W;
    localparam int CMP_W = (ACC_W > PROD_W) ? ACC_W : PROD_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);

    lhp_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                mode_reg, mode_next;
    logic [PROD_W-1:0]   tgt_reg, tgt_next;
    logic [CMP_W-1:0]    acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [BIDX_W-1:0]   out_idx_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [PEAK_W-1:0]   out_peak_reg;
    logic                out_load;

    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [IDX_W-1:0]    div_q;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [BCNT_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [BCNT_W-1:0]   ram_rdata;

    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic [PEAK_W-1:0]   peak;

    logic [CMP_W-1:0]    acc_sum;
    logic                hit;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign div_start = accept && (req.mode == MODE_RECORD);

    // Running sum times 100 reaches count * percent exactly when the running sum
    // reaches the rounded-up target.
    assign acc_sum = CMP_W'(acc_reg + CMP_W'(ram_rdata) * CMP_W'(PCT_SCALE));
    assign hit     = (acc_sum >= CMP_W'(tgt_reg));

    lhp_bucket_ram #(
        .BUCKETS (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lhp_ms_div #(
        .BUCKETS (BUCKETS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ns       (req.duration_ns),
        .done     (div_done),
        .quotient (div_q)
    );

    lhp_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .record (div_start),
        .ns     (req.duration_ns),
        .count  (count),
        .sum    (sum),
        .peak   (peak)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        mode_next      = mode_reg;
        tgt_next       = tgt_reg;
        acc_next       = acc_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        ram_raddr      = idx_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    if (req.mode == MODE_RECORD)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        tgt_next   = PROD_W'(PROD_W'(count) * PROD_W'(req.percent));
                        acc_next   = '0;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_q;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (mode_reg == MODE_QUERY)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we = 1'b1;
                if (ram_rdata == {BCNT_W{1'b1}})
                begin
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_wdata = BCNT_W'(ram_rdata + 1'b1);
                end
                slot_next  = idx_reg;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // Fetch the next bucket while the current one is summed.
                if (idx_reg == LAST)
                begin
                    ram_raddr = '0;
                end
                else
                begin
                    ram_raddr = IDX_W'(idx_reg + 1'b1);
                end
                acc_next = acc_sum;
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (hit)
                begin
                    slot_next  = idx_reg;
                    state_next = ST_DONE;
                end
                else if (idx_reg == LAST)
                begin
                    slot_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        mode_reg <= mode_next;
        tgt_reg  <= tgt_next;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            out_idx_reg   <= BIDX_W'(slot_reg);
            out_count_reg <= count;
            out_sum_reg   <= sum;
            out_peak_reg  <= peak;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.bucket_index  = out_idx_reg;
    assign rsp.sample_count  = out_count_reg;
    assign rsp.total_elapsed = out_sum_reg;
    assign rsp.max_elapsed   = out_peak_reg;

endmodule

// ===== hdl/lhp_bucket_ram.sv =====
// Bucket counter memory: one write port, one read port with registered data.
module lhp_bucket_ram import lhp_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(BUCKETS)-1:0] waddr,
    input  logic [BCNT_W-1:0]          wdata,
    input  logic [$clog2(BUCKETS)-1:0] raddr,
    output logic [BCNT_W-1:0]          rdata
);

    logic [BCNT_W-1:0] mem [BUCKETS];
    logic [BCNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lhp_ms_div.sv =====
// Bucket number of a duration by reciprocal multiplication, clamped to the last bucket.
module lhp_ms_div import lhp_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NS_W-1:0]            ns,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] quotient
);

    localparam int              IDX_W   = $clog2(BUCKETS);
    localparam longint unsigned LIMIT   = longint'(BUCKETS) * NS_PER_MS;
    // Every duration below the clamp limit fits in DIV_N bits for any allowed bucket count.
    localparam int              DIV_N   = 30;
    localparam int              SHIFT   = DIV_N + 20;
    // The rounded-up reciprocal errs by less than 2^(SHIFT-DIV_N), so the quotient is exact
    // for every dividend below 2^DIV_N.
    localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + NS_PER_MS - 64'd1) / NS_PER_MS;
    localparam int              RECIP_W = 31;
    localparam int              MUL_W   = DIV_N + RECIP_W;

    logic [DIV_N-1:0] ns_reg;
    logic             over_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [IDX_W-1:0] q_reg;
    logic [MUL_W-1:0] product;

    assign product = MUL_W'(ns_reg) * MUL_W'(RECIP_W'(RECIP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ns_reg   <= DIV_N'(ns);
            over_reg <= (64'(ns) >= LIMIT);
        end
        if (busy_reg)
        begin
            // Anything at or past the last bucket's upper edge is clamped.
            if (over_reg)
            begin
                q_reg <= IDX_W'(BUCKETS - 1);
            end
            else
            begin
                q_reg <= IDX_W'(product >> SHIFT);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/lhp_stats.sv =====
// Running sample count, wrapping duration sum and peak duration.
module lhp_stats import lhp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               record,
    input  logic [NS_W-1:0]    ns,
    output logic [COUNT_W-1:0] count,
    output logic [SUM_W-1:0]   sum,
    output logic [PEAK_W-1:0]  peak
);

    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PEAK_W-1:0]  peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            peak_reg  <= '0;
        end
        else if (record)
        begin
            if (count_reg != {COUNT_W{1'b1}})
            begin
                count_reg <= COUNT_W'(count_reg + 1'b1);
            end
            sum_reg <= SUM_W'(sum_reg + SUM_W'(ns));
            if (PEAK_W'(ns) > peak_reg)
            begin
                peak_reg <= PEAK_W'(ns);
            end
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign peak  = peak_reg;

endmodule

// ===== tb/latency_histogram_percentile_test.sv =====
// Self-checking testbench for the latency histogram with percentile query.
`timescale 1ns / 1ps

module latency_histogram_percentile_test import lhp_pkg::*; ();

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = BUCKETS_DEF + 8;

    typedef struct {
        logic [BIDX_W-1:0]  bucket_index;
        logic [COUNT_W-1:0] sample_count;
        logic [SUM_W-1:0]   total_elapsed;
        logic [PEAK_W-1:0]  max_elapsed;
    } hist_answer_t;

    class hist_scoreboard;
        logic [BCNT_W-1:0]  bucket_tally [BUCKETS_DEF];
        logic [COUNT_W-1:0] samples;
        logic [SUM_W-1:0]   total;
        logic [PEAK_W-1:0]  peak;
        hist_answer_t       pending_answers [$];
        int                 failures;

        function new();
            foreach (bucket_tally[b])
                bucket_tally[b] = '0;
            samples  = '0;
            total    = '0;
            peak     = '0;
            failures = 0;
        endfunction

        function logic [BIDX_W-1:0] record_sample(logic [NS_W-1:0] ns);
            longint unsigned slot;
            slot = 64'(ns) / NS_PER_MS;
            if (slot >= BUCKETS_DEF)
                slot = BUCKETS_DEF - 1;
            if (bucket_tally[slot] != '1)
                bucket_tally[slot] = bucket_tally[slot] + 1'b1;
            if (samples != '1)
                samples = samples + 1'b1;
            total = total + 64'(ns);
            if (peak < ns)
                peak = ns;
            return BIDX_W'(slot);
        endfunction

        // The target is rounded up; a target past the whole histogram answers bucket zero.
        function logic [BIDX_W-1:0] percentile_bucket(logic [PCT_W-1:0] pct);
            longint unsigned target;
            longint unsigned running;
            target  = (64'(samples) * 64'(pct) + 64'(PCT_SCALE - 1)) / 64'(PCT_SCALE);
            running = 0;
            for (int b = 0; b < BUCKETS_DEF; b++)
            begin
                running += 64'(bucket_tally[b]);
                if (running >= target)
                    return BIDX_W'(b);
            end
            return '0;
        endfunction

        function void note_request(logic mode, logic [NS_W-1:0] ns, logic [PCT_W-1:0] pct);
            hist_answer_t want;
            if (mode == MODE_RECORD)
                want.bucket_index = record_sample(ns);
            else
                want.bucket_index = percentile_bucket(pct);
            want.sample_count  = samples;
            want.total_elapsed = total;
            want.max_elapsed   = peak;
            pending_answers.push_back(want);
        endfunction

        function void check_answer(hist_answer_t got);
            hist_answer_t want;
            bit           bad;
            if (pending_answers.size() == 0)
            begin
                $error("response beat with no request outstanding");
                failures++;
                return;
            end
            want = pending_answers.pop_front();
            bad  = 1'b0;
            if (got.bucket_index !== want.bucket_index)
            begin
                $error("bucket_index: expected %0d, got %0d", want.bucket_index,
                       got.bucket_index);
                bad = 1'b1;
            end
            if (got.sample_count !== want.sample_count)
            begin
                $error("sample_count: expected %0d, got %0d", want.sample_count,
                       got.sample_count);
                bad = 1'b1;
            end
            if (got.total_elapsed !== want.total_elapsed)
            begin
                $error("total_elapsed: expected %0d, got %0d", want.total_elapsed,
                       got.total_elapsed);
                bad = 1'b1;
            end
            if (got.max_elapsed !== want.max_elapsed)
            begin
                $error("max_elapsed: expected %0d, got %0d", want.max_elapsed,
                       got.max_elapsed);
                bad = 1'b1;
            end
            if (bad)
                failures++;
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    bit   clk;
    logic rst_n;
    bit   no_idle;
    bit   hold_rsp;
    bit   rsp_held;

    hist_scoreboard board = new();

    lhp_req_if req ();
    lhp_rsp_if rsp ();

    latency_histogram_percentile i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are checked before the same edge's request is noted, so a result can never
    // be matched against the request that arrives alongside it.
    always @(posedge clk)
    begin
        hist_answer_t got;
        if (rst_n === 1'b1)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.bucket_index  = rsp.bucket_index;
                got.sample_count  = rsp.sample_count;
                got.total_elapsed = rsp.total_elapsed;
                got.max_elapsed   = rsp.max_elapsed;
                board.check_answer(got);
            end
            if (req.valid && req.ready)
                board.note_request(req.mode, req.duration_ns, req.percent);
        end
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_rsp && !rsp_held)
            begin
                rsp_held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp.ready <= no_idle || ($urandom_range(99) >= 27);
            end
        end
    end

    task automatic send_item(logic mode, logic [NS_W-1:0] ns, logic [PCT_W-1:0] pct);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= mode;
        req.duration_ns <= ns;
        req.percent     <= pct;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [NS_W-1:0]  ns;
        logic [PCT_W-1:0] pct;
        int               pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            pct  = PCT_W'($urandom());
            ns   = NS_W'({$urandom(), $urandom()});
            if (pick < 65)
            begin
                pick = $urandom_range(99);
                // Mostly spread over the buckets and just past the last one, some on the
                // millisecond boundaries, the rest over the whole field.
                if (pick < 70)
                    ns = NS_W'(64'($urandom_range(BUCKETS_DEF + 1, 0)) * NS_PER_MS
                               + 64'($urandom_range(999_999, 0)));
                else if (pick < 85)
                    ns = NS_W'(64'($urandom_range(BUCKETS_DEF, 1)) * NS_PER_MS
                               - 64'($urandom_range(1, 0)));
                send_item(MODE_RECORD, ns, pct);
            end
            else
            begin
                if ($urandom_range(99) < 85)
                    pct = PCT_W'($urandom_range(PCT_SCALE, 0));
                else
                    pct = PCT_W'($urandom_range(127, PCT_SCALE + 1));
                send_item(MODE_QUERY, ns, pct);
            end
        end
    endtask

    task automatic wait_for_answers();
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.mode        <= MODE_RECORD;
        req.duration_ns <= '0;
        req.percent     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries on an empty histogram, then bucket edges and long durations, then percentile queries.
        send_item(MODE_QUERY,  '0, PCT_W'(0));
        send_item(MODE_QUERY,  '0, PCT_W'(100));
        send_item(MODE_RECORD, NS_W'(0), '0);
        send_item(MODE_RECORD, NS_W'(999_999), '0);
        send_item(MODE_RECORD, NS_W'(1_000_000), '0);
        send_item(MODE_RECORD, NS_W'(31_999_999), '0);
        send_item(MODE_RECORD, NS_W'(32_000_000), '0);
        send_item(MODE_RECORD, '1, '0);
        send_item(MODE_RECORD, NS_W'(5_500_000), '0);
        send_item(MODE_QUERY,  '0, PCT_W'(0));
        send_item(MODE_QUERY,  '0, PCT_W'(1));
        send_item(MODE_QUERY,  '0, PCT_W'(50));
        send_item(MODE_QUERY,  '0, PCT_W'(99));
        send_item(MODE_QUERY,  '0, PCT_W'(100));
        send_item(MODE_QUERY,  '0, PCT_W'(101));
        send_item(MODE_QUERY,  '0, '1);
        send_item(MODE_RECORD, NS_W'(17_250_000), '0);
        send_item(MODE_QUERY,  '0, PCT_W'(75));
        send_item(MODE_RECORD, NS_W'(0), '1);
        send_item(MODE_QUERY,  '1, PCT_W'(64));

        send_random(450);
        wait_for_answers();

        no_idle = 1'b1;
        send_random(300);
        no_idle = 1'b0;

        // The response side stalls long enough for the block to back up its input.
        hold_rsp = 1'b1;
        send_random(600);

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
